>>> hw/rtl/cbtd_pkg.sv
// Shared types, constants and palette blend function for the texel block decoder.
package cbtd_pkg;

  localparam int unsigned CODES_W    = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CH_W       = 5;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned COLOR_W    = CH_W * NUM_CH;
  localparam int unsigned ALPHA_W    = 5;
  localparam int unsigned PIX_IDX_W  = 4;
  localparam int unsigned NUM_PIX    = 16;
  localparam int unsigned NUM_COLORS = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ALPHA_W-1:0]   ALPHA_OPAQUE = 5'd31;
  localparam logic [ALPHA_W-1:0]   ALPHA_CLEAR  = 5'd0;
  localparam logic [PIX_IDX_W-1:0] LAST_IDX     = 4'd15;
  localparam logic [1:0]           CODE_CLEAR   = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_THREE_CLEAR = 2'd0,
    MODE_HALF_CLEAR  = 2'd1,
    MODE_FOUR        = 2'd2,
    MODE_TWO_BLEND   = 2'd3
  } mode_t;

  typedef logic [COLOR_W-1:0] color_t;

  // One decoded block waiting for the pixel emitter.
  typedef struct packed {
    logic [CODES_W-1:0]           codes;
    logic [NUM_COLORS-1:0][COLOR_W-1:0] palette;
    logic                         code3_clear;
  } block_t;

  // Per-channel floor((wa*a + wb*b) / 8).
  function automatic color_t blend(input color_t a, input color_t b,
                                   input logic [2:0] wa, input logic [2:0] wb);
    color_t     r;
    logic [7:0] s;
    r = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      s = 8'(wa) * 8'(a[CH_W*k +: CH_W]) + 8'(wb) * 8'(b[CH_W*k +: CH_W]);
      r[CH_W*k +: CH_W] = s[7:3];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/cbtd_blk_if.sv
// Block input channel: valid/ready handshake with codes, mode and palette colors.
interface cbtd_blk_if;
  logic                          valid;
  logic                          ready;
  logic [cbtd_pkg::CODES_W-1:0]  texel_bits;
  logic [cbtd_pkg::MODE_W-1:0]   mode;
  logic [cbtd_pkg::COLOR_W-1:0]  color_zero;
  logic [cbtd_pkg::COLOR_W-1:0]  color_one;
  logic [cbtd_pkg::COLOR_W-1:0]  color_two;
  logic [cbtd_pkg::COLOR_W-1:0]  color_three;

  modport source (output valid, texel_bits, mode, color_zero, color_one, color_two,
                  color_three, input ready);
  modport sink (input valid, texel_bits, mode, color_zero, color_one, color_two,
                color_three, output ready);
endinterface

>>> hw/rtl/cbtd_pix_if.sv
// Pixel output channel: valid/ready handshake with one decoded pixel.
interface cbtd_pix_if;
  logic                            valid;
  logic                            ready;
  logic [cbtd_pkg::ALPHA_W-1:0]    pixel_alpha;
  logic [cbtd_pkg::COLOR_W-1:0]    pixel_color;
  logic [cbtd_pkg::PIX_IDX_W-1:0]  pixel_index;
  logic                            last_pixel;

  modport source (output valid, pixel_alpha, pixel_color, pixel_index, last_pixel,
                  input ready);
  modport sink (input valid, pixel_alpha, pixel_color, pixel_index, last_pixel,
                output ready);
endinterface

>>> hw/rtl/compressed_block_texture_decode.sv
// Top level of the 4x4 compressed texel block decoder.
//
//   channel   dir   handshake      payload
//   blk_in    in    valid/ready    texel_bits, mode, color_zero..color_three
//   pix_out   out   valid/ready    pixel_alpha, pixel_color, pixel_index, last_pixel
//
// Each block yields sixteen pixels, one per cycle while pix_out is ready, a rate
// set by the pixel emitter's single output port.
// Pixels pass the queue entry, the block register and the pixel output register.
// Blocks are taken while earlier ones are still emitting, up to the queue depth.
// Synchronous active-high reset clears the queue and emitter; no clearing pass.
// A stalled pix_out holds the current pixel and backs up into the queue.
module compressed_block_texture_decode #(
  parameter int unsigned QUEUE_DEPTH = cbtd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  cbtd_blk_if.sink    blk_in,
  cbtd_pix_if.source  pix_out
);

  logic              push_valid;
  logic              push_ready;
  cbtd_pkg::block_t  push_data;
  logic              pop_valid;
  logic              pop_ready;
  cbtd_pkg::block_t  pop_data;

  cbtd_front u_front (
    .blk_in     (blk_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cbtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cbtd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .pix_out   (pix_out)
  );

endmodule

>>> hw/rtl/cbtd_front.sv
// Front end: accepts a block, builds its four-entry palette and transparency flag.
module cbtd_front (
  cbtd_blk_if.sink          blk_in,
  output logic              push_valid,
  input  logic              push_ready,
  output cbtd_pkg::block_t  push_data
);

  cbtd_pkg::mode_t mode;

  assign mode          = cbtd_pkg::mode_t'(blk_in.mode);
  assign blk_in.ready  = push_ready;
  assign push_valid    = blk_in.valid;

  always_comb begin
    push_data.codes      = blk_in.texel_bits;
    push_data.palette[0] = blk_in.color_zero;
    push_data.palette[1] = blk_in.color_one;
    push_data.palette[2] = blk_in.color_two;
    push_data.palette[3] = blk_in.color_three;
    push_data.code3_clear = 1'b0;
    case (mode)
      cbtd_pkg::MODE_TWO_BLEND: begin
        push_data.palette[2] = cbtd_pkg::blend(blk_in.color_zero, blk_in.color_one,
                                               3'd5, 3'd3);
        push_data.palette[3] = cbtd_pkg::blend(blk_in.color_zero, blk_in.color_one,
                                               3'd3, 3'd5);
      end
      cbtd_pkg::MODE_HALF_CLEAR: begin
        push_data.palette[2] = cbtd_pkg::blend(blk_in.color_zero, blk_in.color_one,
                                               3'd4, 3'd4);
        push_data.code3_clear = 1'b1;
      end
      cbtd_pkg::MODE_THREE_CLEAR: begin
        push_data.code3_clear = 1'b1;
      end
      default: begin
        push_data.code3_clear = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/cbtd_queue.sv
// Short block queue between the palette builder and the pixel emitter.
module cbtd_queue #(
  parameter int unsigned DEPTH = cbtd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  cbtd_pkg::block_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output cbtd_pkg::block_t  pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cbtd_pkg::block_t  entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/cbtd_back.sv
// Back end: walks a block's 16 codes, one pixel per cycle unless stalled.
module cbtd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  cbtd_pkg::block_t  pop_data,
  cbtd_pix_if.source        pix_out
);

  cbtd_pkg::block_t                blk;
  logic                            busy;
  logic [cbtd_pkg::PIX_IDX_W-1:0]  cnt;
  logic                            out_valid;
  logic [cbtd_pkg::ALPHA_W-1:0]    out_alpha;
  logic [cbtd_pkg::COLOR_W-1:0]    out_color;
  logic [cbtd_pkg::PIX_IDX_W-1:0]  out_index;
  logic                            out_last;
  logic                            emit;
  logic                            at_last;
  logic [1:0]                      code;

  assign at_last     = (cnt == cbtd_pkg::LAST_IDX);
  assign emit        = busy && (!out_valid || pix_out.ready);
  assign pop_ready   = !busy || (emit && at_last);
  assign code        = blk.codes[{cnt, 1'b0} +: 2];

  assign pix_out.valid       = out_valid;
  assign pix_out.pixel_alpha = out_alpha;
  assign pix_out.pixel_color = out_color;
  assign pix_out.pixel_index = out_index;
  assign pix_out.last_pixel  = out_last;

  // Pixel payload and block registers carry no reset.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_alpha <= (blk.code3_clear && code == cbtd_pkg::CODE_CLEAR) ?
                   cbtd_pkg::ALPHA_CLEAR : cbtd_pkg::ALPHA_OPAQUE;
      out_color <= blk.palette[code];
      out_index <= cnt;
      out_last  <= at_last;
    end
    if (pop_valid && pop_ready) begin
      blk <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
      // Load the next block right behind the last pixel of the current one.
      if (pop_valid && pop_ready) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (emit) begin
        cnt <= cnt + cbtd_pkg::PIX_IDX_W'(1);
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
